// ===== rtl/single_source_shortest_paths_defines.svh =====
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_DEFINES_SVH

// check that holds in the same cycle as its condition
`define SSP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check that holds in the cycle after its condition
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ssp_pkg.sv =====
`default_nettype none

package ssp_pkg;

   // fixed field widths
   localparam int VERT_BITS         = 6;
   localparam int MAX_VERTICES      = 64;
   localparam int NV_BITS           = $clog2(MAX_VERTICES + 1);
   localparam int DIST_BITS         = 32;
   localparam int CAND_BITS         = DIST_BITS + 1;
   localparam int IN_WEIGHT_BITS    = 16;
   localparam int WEIGHT_WIDE_BITS  = 32;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int CSR_DATA_BITS     = 7;

   // register reset values
   localparam logic [NV_BITS-1:0]   VERTEX_COUNT_RESET = NV_BITS'(MAX_VERTICES);
   localparam logic [VERT_BITS-1:0] SOURCE_RESET       = '0;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_RUN    = 2'd1,
      OP_CLEAR  = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VERTEX_COUNT  = 1'd0,
      CSR_SOURCE_VERTEX = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DREAD,
      ST_RELAX,
      ST_EMIT_RD,
      ST_EMIT_LOAD
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]                       opcode;
      logic [VERT_BITS-1:0]             edge_from;
      logic [VERT_BITS-1:0]             edge_to;
      logic signed [IN_WEIGHT_BITS-1:0] edge_weight_in;
   } req_payload_type;

   typedef struct packed {
      logic [VERT_BITS-1:0]        vertex_index;
      logic signed [DIST_BITS-1:0] distance;
      logic                        reachable;
      logic                        negative_cycle;
      logic                        edge_overflow;
      logic                        last;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic append;
      logic clear;
      logic run_start;
      logic edge_fetch;
      logic dist_read;
      logic relax;
      logic edge_next;
      logic pass_next;
      logic emit_read;
      logic emit_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic edge_empty;
      logic edge_last;
      logic check_pass;
      logic vertex_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/ssp_chan_if.sv =====
`default_nettype none

interface ssp_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/single_source_shortest_paths.sv =====
// Single-source shortest paths over a loaded list of directed weighted edges.
// req_chan carries one item per transfer: append an edge, clear the edge list,
// or run the search from the configured source vertex. rsp_chan carries one
// result per vertex (0 .. vertex_count-1, vertex_count clamped to 1 .. 64) with
// distance, reachable, negative cycle and store overflow flags, and last on the final one.
// csr_* writes vertex_count (index 0) and source_vertex (index 1); write only
// while no run is in progress and all results have been taken.
// Append and clear each complete on their transfer, so edges load at one per
// cycle while no run is in progress. A run makes vertex_count passes over the
// edge store (vertex_count-1 relaxing passes plus one negative cycle check
// pass); each pass fetches the first edge from the single-port edge memory and
// then does a read-modify-write of the distance memory per edge; with an empty
// store no pass runs. Each result is then read from the distance memory and
// loaded into the output register before the next is read. req_chan.ready is low
// from a run transfer until the last result is loaded into the output register.
// The output register holds a result while rsp_chan.ready is low and the
// emit sequence waits for it; appends and clears wait until the last result is loaded.
// Synchronous reset clears the edge count, overflow flag and reach bits and
// restores vertex_count to 64 and source_vertex to 0; no clearing pass runs.
`default_nettype none

module single_source_shortest_paths
   import ssp_pkg::*;
#(
   parameter int MAX_EDGES   = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   ssp_chan_if.sink                       req_chan,
   ssp_chan_if.source                     rsp_chan,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   dp_cmd_type      cmd;
   dp_status_type   status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic            req_ready;
   logic            rsp_valid;

   assign req_payload      = req_chan.payload;
   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

   // sequencer
   ssp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_payload.opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // edge store, distance store and result register
   ssp_dpath #(
      .MAX_EDGES   (MAX_EDGES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_payload    (req_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== rtl/ssp_ctrl.sv =====
`default_nettype none
`include "single_source_shortest_paths_defines.svh"

module ssp_ctrl
   import ssp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [1:0]    req_opcode,
   output logic               req_ready,
   input  dp_status_type      status,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_opcode)
                  OP_APPEND: begin
                     cmd.append = 1'b1;
                  end
                  OP_RUN: begin
                     cmd.run_start = 1'b1;
                     state_in      = ST_FETCH;
                  end
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            if (status.edge_empty) begin
               state_in = ST_EMIT_RD;
            end else begin
               cmd.edge_fetch = 1'b1;
               state_in       = ST_DREAD;
            end
         end
         ST_DREAD: begin
            cmd.dist_read = 1'b1;
            state_in      = ST_RELAX;
         end
         ST_RELAX: begin
            cmd.relax = 1'b1;
            if (status.edge_last) begin
               cmd.pass_next = 1'b1;
               state_in      = status.check_pass ? ST_EMIT_RD : ST_FETCH;
            end else begin
               cmd.edge_next = 1'b1;
               state_in      = ST_DREAD;
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = status.vertex_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // checks
   `SSP_ASSERT_NEXT(a_run_starts_search, state_ff == ST_IDLE && req_valid && req_opcode == OP_RUN, state_ff == ST_FETCH, "run transfer did not start the search")
   `SSP_ASSERT_NOW(a_load_needs_room, cmd.emit_load, status.out_free, "result loaded over a pending transfer")
   `SSP_ASSERT_NEXT(a_relax_walks_on, state_ff == ST_RELAX && !status.edge_last, state_ff == ST_DREAD, "edge walk stopped early")

endmodule

`default_nettype wire

// ===== rtl/ssp_dpath.sv =====
`default_nettype none
`include "single_source_shortest_paths_defines.svh"

module ssp_dpath
   import ssp_pkg::*;
#(
   parameter int MAX_EDGES   = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  dp_cmd_type                     cmd,
   output dp_status_type                  status,
   input  req_payload_type                req_payload,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output rsp_payload_type                rsp_payload
);

   localparam int EDGE_CNT_BITS  = $clog2(MAX_EDGES + 1);
   localparam int EDGE_IDX_BITS  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_WORD_BITS = 2 * VERT_BITS + WEIGHT_BITS;
   localparam logic [EDGE_CNT_BITS-1:0] EDGE_LIMIT = EDGE_CNT_BITS'(MAX_EDGES);
   localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
   localparam logic signed [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

   // configuration
   logic [NV_BITS-1:0]   vertex_count_ff;
   logic [VERT_BITS-1:0] source_ff;

   // edge list
   logic [EDGE_WORD_BITS-1:0] edge_mem_ff [MAX_EDGES];
   logic [EDGE_WORD_BITS-1:0] edge_rd_ff;
   logic [EDGE_CNT_BITS-1:0]  edge_total_ff;
   logic                      overflow_ff;
   logic [EDGE_IDX_BITS-1:0]  edge_idx_ff;
   logic [EDGE_IDX_BITS-1:0]  edge_rd_addr;
   logic                      edge_full;
   logic [WEIGHT_WIDE_BITS-1:0] weight_wide;

   // search state
   logic signed [DIST_BITS-1:0] dist_mem_ff [MAX_VERTICES];
   logic signed [DIST_BITS-1:0] dist_a_ff;
   logic signed [DIST_BITS-1:0] dist_b_ff;
   logic [MAX_VERTICES-1:0]     reach_ff;
   logic                        reach_u_ff;
   logic                        reach_v_ff;
   logic                        in_range_ff;
   logic                        cycle_ff;
   logic [NV_BITS-1:0]          nv_ff;
   logic [NV_BITS-1:0]          nv_calc;
   logic [NV_BITS-1:0]          pass_ff;
   logic [VERT_BITS-1:0]        vidx_ff;
   logic                        src_ok;

   // relaxation
   logic [VERT_BITS-1:0]         edge_tail;
   logic [VERT_BITS-1:0]         edge_head;
   logic [WEIGHT_BITS-1:0]       edge_weight;
   logic signed [CAND_BITS-1:0]  weight_ext;
   logic signed [CAND_BITS-1:0]  cand;
   logic signed [CAND_BITS-1:0]  dist_v_ext;
   logic signed [DIST_BITS-1:0]  cand_sat;
   logic                         relax_hit;
   logic [VERT_BITS-1:0]         dist_addr_a;
   logic                         dist_we;
   logic [VERT_BITS-1:0]         dist_waddr;
   logic signed [DIST_BITS-1:0]  dist_wdata;

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   // vertex count clamp and source check
   always_comb begin
      if (vertex_count_ff == '0) begin
         nv_calc = NV_BITS'(1);
      end else if (vertex_count_ff > NV_BITS'(MAX_VERTICES)) begin
         nv_calc = NV_BITS'(MAX_VERTICES);
      end else begin
         nv_calc = vertex_count_ff;
      end
   end
   assign src_ok = NV_BITS'(source_ff) < nv_calc;

   // edge word fields
   assign edge_tail   = edge_rd_ff[EDGE_WORD_BITS-1 -: VERT_BITS];
   assign edge_head   = edge_rd_ff[WEIGHT_BITS +: VERT_BITS];
   assign edge_weight = edge_rd_ff[WEIGHT_BITS-1:0];
   assign weight_wide = {{(WEIGHT_WIDE_BITS-IN_WEIGHT_BITS){1'b0}}, req_payload.edge_weight_in};
   assign edge_full   = edge_total_ff == EDGE_LIMIT;
   assign edge_rd_addr = cmd.edge_next ? edge_idx_ff + EDGE_IDX_BITS'(1) : edge_idx_ff;

   // candidate distance and improvement test
   assign weight_ext = {{(CAND_BITS-WEIGHT_BITS){edge_weight[WEIGHT_BITS-1]}}, edge_weight};
   assign cand       = {dist_a_ff[DIST_BITS-1], dist_a_ff} + weight_ext;
   assign dist_v_ext = {dist_b_ff[DIST_BITS-1], dist_b_ff};
   assign relax_hit  = in_range_ff && reach_u_ff && (!reach_v_ff || cand < dist_v_ext);

   // saturate to the signed distance range
   always_comb begin
      if (cand[CAND_BITS-1] != cand[CAND_BITS-2]) begin
         cand_sat = cand[CAND_BITS-1] ? DIST_MIN : DIST_MAX;
      end else begin
         cand_sat = cand[DIST_BITS-1:0];
      end
   end

   // distance store port selection
   assign dist_addr_a = cmd.emit_read ? vidx_ff : edge_tail;
   always_comb begin
      dist_we    = 1'b0;
      dist_waddr = edge_head;
      dist_wdata = cand_sat;
      if (cmd.run_start && src_ok) begin
         dist_we    = 1'b1;
         dist_waddr = source_ff;
         dist_wdata = '0;
      end else if (cmd.relax && relax_hit && !status.check_pass) begin
         dist_we = 1'b1;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
         source_ff       <= SOURCE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_VERTEX_COUNT:  vertex_count_ff <= csr_write_data;
            CSR_SOURCE_VERTEX: source_ff       <= csr_write_data[VERT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // edge count and overflow flag
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_total_ff <= '0;
         overflow_ff   <= 1'b0;
      end else if (cmd.clear) begin
         edge_total_ff <= '0;
         overflow_ff   <= 1'b0;
      end else if (cmd.append) begin
         if (edge_full) begin
            overflow_ff <= 1'b1;
         end else begin
            edge_total_ff <= edge_total_ff + EDGE_CNT_BITS'(1);
         end
      end
   end

   // edge memory
   always_ff @(posedge clock) begin
      if (cmd.append && !edge_full) begin
         edge_mem_ff[edge_total_ff[EDGE_IDX_BITS-1:0]] <=
            {req_payload.edge_from, req_payload.edge_to, weight_wide[WEIGHT_BITS-1:0]};
      end
      if (cmd.edge_fetch || cmd.edge_next) begin
         edge_rd_ff <= edge_mem_ff[edge_rd_addr];
      end
   end

   // distance memory, two registered read ports
   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem_ff[dist_waddr] <= dist_wdata;
      end
      if (cmd.dist_read || cmd.emit_read) begin
         dist_a_ff <= dist_mem_ff[dist_addr_a];
      end
      if (cmd.dist_read) begin
         dist_b_ff <= dist_mem_ff[edge_head];
      end
   end

   // operands captured alongside the distance reads
   always_ff @(posedge clock) begin
      if (cmd.dist_read) begin
         reach_u_ff  <= reach_ff[edge_tail];
         reach_v_ff  <= reach_ff[edge_head];
         in_range_ff <= (NV_BITS'(edge_tail) < nv_ff) && (NV_BITS'(edge_head) < nv_ff);
      end
   end

   // run sequencing counters, reach bits and cycle flag
   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff    <= '0;
         cycle_ff    <= 1'b0;
         nv_ff       <= NV_BITS'(1);
         pass_ff     <= NV_BITS'(1);
         edge_idx_ff <= '0;
         vidx_ff     <= '0;
      end else begin
         if (cmd.run_start) begin
            reach_ff    <= src_ok ? (MAX_VERTICES'(1) << source_ff) : '0;
            cycle_ff    <= 1'b0;
            nv_ff       <= nv_calc;
            pass_ff     <= NV_BITS'(1);
            edge_idx_ff <= '0;
            vidx_ff     <= '0;
         end
         if (cmd.relax && relax_hit) begin
            if (status.check_pass) begin
               cycle_ff <= 1'b1;
            end else begin
               reach_ff[edge_head] <= 1'b1;
            end
         end
         if (cmd.edge_next) begin
            edge_idx_ff <= edge_idx_ff + EDGE_IDX_BITS'(1);
         end
         if (cmd.pass_next) begin
            edge_idx_ff <= '0;
            pass_ff     <= pass_ff + NV_BITS'(1);
         end
         if (cmd.emit_load) begin
            vidx_ff <= vidx_ff + VERT_BITS'(1);
         end
      end
   end

   // status back to the controller
   assign status.edge_empty  = edge_total_ff == '0;
   assign status.edge_last   = EDGE_CNT_BITS'(edge_idx_ff) == edge_total_ff - EDGE_CNT_BITS'(1);
   assign status.check_pass  = pass_ff == nv_ff;
   assign status.vertex_last = NV_BITS'(vidx_ff) == nv_ff - NV_BITS'(1);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_payload_ff.vertex_index   <= vidx_ff;
         rsp_payload_ff.distance       <= reach_ff[vidx_ff] ? dist_a_ff : '0;
         rsp_payload_ff.reachable      <= reach_ff[vidx_ff];
         rsp_payload_ff.negative_cycle <= cycle_ff;
         rsp_payload_ff.edge_overflow  <= overflow_ff;
         rsp_payload_ff.last           <= status.vertex_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   `SSP_ASSERT_NOW(a_edge_total_bound, 1'b1, edge_total_ff <= EDGE_LIMIT, "edge count beyond store depth")
   `SSP_ASSERT_NEXT(a_relax_marks_head, cmd.relax && relax_hit && !status.check_pass, reach_ff[$past(edge_head)], "relaxed vertex not marked reachable")
   `SSP_ASSERT_NOW(a_overflow_clears_on_clear, $fell(overflow_ff), $past(cmd.clear) || $past(reset), "overflow flag dropped without a clear")

endmodule

`default_nettype wire
